// ===== rtl/wfv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wfv_pkg;

  // Config field widths and reset values
  localparam int BORE_LEN_W = 10;
  localparam int JET_LEN_W  = 9;
  localparam int GAIN_W     = 15;
  localparam int RATE_DIV_W = 5;
  localparam int DIV_CNT_W  = 4;

  localparam logic [BORE_LEN_W-1:0] BORE_LEN_RST   = 10'd100;
  localparam logic [JET_LEN_W-1:0]  JET_LEN_RST    = 9'd25;
  localparam logic [GAIN_W-1:0]     JET_GAIN_RST   = 15'd13763;
  localparam logic [GAIN_W-1:0]     REED_GAIN_RST  = 15'd17367;
  localparam logic [GAIN_W-1:0]     LP_COEF_RST    = 15'd19661;
  localparam logic [RATE_DIV_W-1:0] RATE_DIV_RST   = 5'd1;
  localparam logic [RATE_DIV_W-1:0] RATE_DIV_MAX   = 5'd16;

  // DC blocker pole, 0.99 in Q1.15
  localparam logic [GAIN_W-1:0] DC_GAIN_Q15 = 15'd32440;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_BORE_LEN  = 3'd0,
    REG_JET_LEN   = 3'd1,
    REG_JET_GAIN  = 3'd2,
    REG_REED_GAIN = 3'd3,
    REG_LP_COEF   = 3'd4,
    REG_RATE_DIV  = 3'd5
  } reg_idx_t;

  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_CLEAR    = 16'h0002,
    ST_MUL_JET  = 16'h0004,
    ST_JET_WR   = 16'h0008,
    ST_JET_RD   = 16'h0010,
    ST_MUL_XX   = 16'h0020,
    ST_SQ       = 16'h0040,
    ST_MUL_CUBE = 16'h0080,
    ST_SHAPE    = 16'h0100,
    ST_MUL_REED = 16'h0200,
    ST_REFL     = 16'h0400,
    ST_MUL_LP   = 16'h0800,
    ST_LP_WR    = 16'h1000,
    ST_MUL_DC   = 16'h2000,
    ST_DC_OUT   = 16'h4000,
    ST_EMIT     = 16'h8000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/waveguide_flute_voice.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Waveguide flute voice. Each input transaction carries one breath-pressure
// sample (in_tdata, signed Q2.13) or, with in_tuser set, a note restart that
// rewinds the jet and bore ring pointers and returns nothing. Every pressure
// transaction returns one output transaction: audio in out_tdata and a fresh
// flag in out_tuser; only one sample in every rate_divider is computed, the
// others repeat the last computed sample with fresh low. The divider count runs
// across transactions and is not cleared by a restart. All math goes through a
// single signed multiplier under a 16-state sequencer, with rounding and
// saturation after every product. A computed sample runs from acceptance
// through 13 multiply/update steps and an output load; a held sample goes
// straight to the output load and a restart leaves the block idle. The six
// dependent products on the one multiplier and the single port of each ring
// memory set the sequence length. After reset the block sweeps both rings to
// zero, one entry per cycle, over max(BORE_DEPTH, JET_DEPTH) entries (1024 at
// the defaults) with in_tready low; the APB registers are writable throughout.
// Registers (byte address 4*i): bore_length, jet_length, jet_reflect_gain,
// reed_reflect_gain, lowpass_coef, rate_divider. Write them only while idle.
module waveguide_flute_voice #(
  parameter int BORE_DEPTH  = 1024,
  parameter int JET_DEPTH   = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,

  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,   // [SAMPLE_BITS-1:0] pressure
  input  logic [0:0]                          in_tuser,   // [0] mode (1 = restart)

  // output stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    out_tdata,  // [SAMPLE_BITS-1:0] audio
  output logic [0:0]                          out_tuser,  // [0] fresh

  // APB config
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [wfv_pkg::APB_ADDR_W-1:0]      cfg_paddr,
  input  logic [wfv_pkg::APB_DATA_W-1:0]      cfg_pwdata,
  output logic [wfv_pkg::APB_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  localparam int SB      = SAMPLE_BITS;
  localparam int TD_W    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int MB_W    = (SB > 16) ? SB : 16;
  localparam int PW      = SB + 1 + MB_W;    // product width
  localparam int SW      = PW + 1;           // sum width before saturation
  localparam int BP_W    = $clog2(BORE_DEPTH);
  localparam int JP_W    = $clog2(JET_DEPTH);
  localparam int MAX_DEPTH = (BORE_DEPTH > JET_DEPTH) ? BORE_DEPTH : JET_DEPTH;
  localparam int CLR_W   = $clog2(MAX_DEPTH);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(MAX_DEPTH - 1);

  localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
  localparam logic signed [PW-1:0] HALF15 = PW'(16384);
  localparam logic signed [PW-1:0] HALF13 = PW'(4096);

  function automatic logic signed [SB-1:0] sat_f(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = v;
    if (v > SMAX) begin
      c = SMAX;
    end else if (v < SMIN) begin
      c = SMIN;
    end
    return c[SB-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [wfv_pkg::BORE_LEN_W-1:0] bore_len_r;
  logic [wfv_pkg::JET_LEN_W-1:0]  jet_len_r;
  logic [wfv_pkg::GAIN_W-1:0]     jet_gain_r;
  logic [wfv_pkg::GAIN_W-1:0]     reed_gain_r;
  logic [wfv_pkg::GAIN_W-1:0]     lp_coef_r;
  logic [wfv_pkg::RATE_DIV_W-1:0] rate_div_r;

  logic cfg_wr;
  wfv_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = wfv_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bore_len_r  <= wfv_pkg::BORE_LEN_RST;
      jet_len_r   <= wfv_pkg::JET_LEN_RST;
      jet_gain_r  <= wfv_pkg::JET_GAIN_RST;
      reed_gain_r <= wfv_pkg::REED_GAIN_RST;
      lp_coef_r   <= wfv_pkg::LP_COEF_RST;
      rate_div_r  <= wfv_pkg::RATE_DIV_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wfv_pkg::REG_BORE_LEN:  bore_len_r  <= cfg_pwdata[wfv_pkg::BORE_LEN_W-1:0];
        wfv_pkg::REG_JET_LEN:   jet_len_r   <= cfg_pwdata[wfv_pkg::JET_LEN_W-1:0];
        wfv_pkg::REG_JET_GAIN:  jet_gain_r  <= cfg_pwdata[wfv_pkg::GAIN_W-1:0];
        wfv_pkg::REG_REED_GAIN: reed_gain_r <= cfg_pwdata[wfv_pkg::GAIN_W-1:0];
        wfv_pkg::REG_LP_COEF:   lp_coef_r   <= cfg_pwdata[wfv_pkg::GAIN_W-1:0];
        wfv_pkg::REG_RATE_DIV:  rate_div_r  <= cfg_pwdata[wfv_pkg::RATE_DIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      wfv_pkg::REG_BORE_LEN:  cfg_prdata = wfv_pkg::APB_DATA_W'(bore_len_r);
      wfv_pkg::REG_JET_LEN:   cfg_prdata = wfv_pkg::APB_DATA_W'(jet_len_r);
      wfv_pkg::REG_JET_GAIN:  cfg_prdata = wfv_pkg::APB_DATA_W'(jet_gain_r);
      wfv_pkg::REG_REED_GAIN: cfg_prdata = wfv_pkg::APB_DATA_W'(reed_gain_r);
      wfv_pkg::REG_LP_COEF:   cfg_prdata = wfv_pkg::APB_DATA_W'(lp_coef_r);
      wfv_pkg::REG_RATE_DIV:  cfg_prdata = wfv_pkg::APB_DATA_W'(rate_div_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // Effective ring lengths, clamped to what the stores hold
  logic [BP_W-1:0] blen;
  logic [JP_W-1:0] jlen;
  logic [wfv_pkg::RATE_DIV_W-1:0] div_eff;

  always_comb begin
    if (32'(bore_len_r) > BORE_DEPTH - 1) begin
      blen = BP_W'(BORE_DEPTH - 1);
    end else begin
      blen = BP_W'(bore_len_r);
    end
    if (32'(jet_len_r) > JET_DEPTH - 1) begin
      jlen = JP_W'(JET_DEPTH - 1);
    end else begin
      jlen = JP_W'(jet_len_r);
    end
    if (rate_div_r == '0) begin
      div_eff = wfv_pkg::RATE_DIV_W'(1);
    end else if (rate_div_r > wfv_pkg::RATE_DIV_MAX) begin
      div_eff = wfv_pkg::RATE_DIV_MAX;
    end else begin
      div_eff = rate_div_r;
    end
  end

  // ---------------------------------------------------------------- state
  wfv_pkg::state_t state_r, state_nxt;

  logic [CLR_W-1:0] clr_r;
  logic [BP_W-1:0]  bw_r, br_r;
  logic [JP_W-1:0]  jw_r, jr_r;
  logic [wfv_pkg::DIV_CNT_W-1:0] div_cnt_r;

  logic signed [SB-1:0] bore_out_r, lp_prev_r, dc_in_r, dc_out_r, held_r;
  logic signed [SB-1:0] p_r, tmp_r;
  logic signed [SB-1:0] jet_rd_r, bore_rd_r;
  logic signed [PW-1:0] prod_r;
  logic                 fresh_r;

  logic                 out_tvalid_r;
  logic [SB-1:0]        out_audio_r;
  logic                 out_fresh_r;

  logic in_acc, out_free;
  assign in_tready = (state_r == wfv_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // Divider count step
  logic [wfv_pkg::RATE_DIV_W-1:0] cnt_inc;
  logic [wfv_pkg::DIV_CNT_W-1:0]  cnt_step;
  assign cnt_inc  = wfv_pkg::RATE_DIV_W'(div_cnt_r) + wfv_pkg::RATE_DIV_W'(1);
  assign cnt_step = (cnt_inc >= div_eff) ? '0 : cnt_inc[wfv_pkg::DIV_CNT_W-1:0];

  // Ring pointer advance, wrap past the length
  logic [BP_W:0] bw_inc, br_inc;
  logic [JP_W:0] jw_inc, jr_inc;
  logic [BP_W-1:0] bw_adv, br_adv;
  logic [JP_W-1:0] jw_adv, jr_adv;

  always_comb begin
    bw_inc = (BP_W+1)'(bw_r) + (BP_W+1)'(1);
    br_inc = (BP_W+1)'(br_r) + (BP_W+1)'(1);
    jw_inc = (JP_W+1)'(jw_r) + (JP_W+1)'(1);
    jr_inc = (JP_W+1)'(jr_r) + (JP_W+1)'(1);
    bw_adv = (bw_inc > (BP_W+1)'(blen)) ? '0 : bw_inc[BP_W-1:0];
    br_adv = (br_inc > (BP_W+1)'(blen)) ? '0 : br_inc[BP_W-1:0];
    jw_adv = (jw_inc > (JP_W+1)'(jlen)) ? '0 : jw_inc[JP_W-1:0];
    jr_adv = (jr_inc > (JP_W+1)'(jlen)) ? '0 : jr_inc[JP_W-1:0];
  end

  // ---------------------------------------------------------------- shared multiplier
  logic signed [SB:0]     mul_a;
  logic signed [MB_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      wfv_pkg::ST_MUL_JET: begin
        mul_a = (SB+1)'(bore_out_r);
        mul_b = MB_W'({1'b0, jet_gain_r});
      end
      wfv_pkg::ST_MUL_XX: begin
        mul_a = (SB+1)'(jet_rd_r);
        mul_b = MB_W'(jet_rd_r);
      end
      wfv_pkg::ST_MUL_CUBE: begin       // x^2 * x
        mul_a = (SB+1)'(tmp_r);
        mul_b = MB_W'(jet_rd_r);
      end
      wfv_pkg::ST_MUL_REED: begin
        mul_a = (SB+1)'(bore_out_r);
        mul_b = MB_W'({1'b0, reed_gain_r});
      end
      wfv_pkg::ST_MUL_LP: begin         // (r - lp_prev) * c
        mul_a = (SB+1)'(tmp_r) - (SB+1)'(lp_prev_r);
        mul_b = MB_W'({1'b0, lp_coef_r});
      end
      wfv_pkg::ST_MUL_DC: begin
        mul_a = (SB+1)'(dc_out_r);
        mul_b = MB_W'({1'b0, wfv_pkg::DC_GAIN_Q15});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Round half up, then drop the fraction
  logic signed [PW-1:0] r15, r13;
  assign r15 = (prod_r + HALF15) >>> 15;
  assign r13 = (prod_r + HALF13) >>> 13;

  logic signed [SB-1:0] jet_in, lp_new, y_new;
  assign jet_in = sat_f(SW'(p_r) + SW'(r15));
  assign lp_new = sat_f(SW'(lp_prev_r) + SW'(r15));
  assign y_new  = sat_f(SW'(lp_prev_r) - SW'(dc_in_r) + SW'(r15));

  // ---------------------------------------------------------------- rings
  logic signed [SB-1:0] bore_mem [BORE_DEPTH];
  logic signed [SB-1:0] jet_mem  [JET_DEPTH];

  logic clearing, bore_clr, jet_clr;
  assign clearing = (state_r == wfv_pkg::ST_CLEAR);
  assign bore_clr = clearing && (32'(clr_r) < BORE_DEPTH);
  assign jet_clr  = clearing && (32'(clr_r) < JET_DEPTH);

  always_ff @(posedge clk) begin
    if (bore_clr) begin
      bore_mem[clr_r[BP_W-1:0]] <= '0;
    end else if (state_r == wfv_pkg::ST_LP_WR) begin
      bore_mem[bw_r] <= lp_new;
    end
    if (state_r == wfv_pkg::ST_MUL_DC) begin
      bore_rd_r <= bore_mem[br_r];
    end
  end

  always_ff @(posedge clk) begin
    if (jet_clr) begin
      jet_mem[clr_r[JP_W-1:0]] <= '0;
    end else if (state_r == wfv_pkg::ST_JET_WR) begin
      jet_mem[jw_r] <= jet_in;
    end
    if (state_r == wfv_pkg::ST_JET_RD) begin
      jet_rd_r <= jet_mem[jr_r];
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wfv_pkg::ST_IDLE: begin
        if (in_acc && !in_tuser[0]) begin
          state_nxt = (div_cnt_r == '0) ? wfv_pkg::ST_MUL_JET : wfv_pkg::ST_EMIT;
        end
      end
      wfv_pkg::ST_CLEAR: begin
        if (clr_r == CLR_LAST) begin
          state_nxt = wfv_pkg::ST_IDLE;
        end
      end
      wfv_pkg::ST_MUL_JET:  state_nxt = wfv_pkg::ST_JET_WR;
      wfv_pkg::ST_JET_WR:   state_nxt = wfv_pkg::ST_JET_RD;
      wfv_pkg::ST_JET_RD:   state_nxt = wfv_pkg::ST_MUL_XX;
      wfv_pkg::ST_MUL_XX:   state_nxt = wfv_pkg::ST_SQ;
      wfv_pkg::ST_SQ:       state_nxt = wfv_pkg::ST_MUL_CUBE;
      wfv_pkg::ST_MUL_CUBE: state_nxt = wfv_pkg::ST_SHAPE;
      wfv_pkg::ST_SHAPE:    state_nxt = wfv_pkg::ST_MUL_REED;
      wfv_pkg::ST_MUL_REED: state_nxt = wfv_pkg::ST_REFL;
      wfv_pkg::ST_REFL:     state_nxt = wfv_pkg::ST_MUL_LP;
      wfv_pkg::ST_MUL_LP:   state_nxt = wfv_pkg::ST_LP_WR;
      wfv_pkg::ST_LP_WR:    state_nxt = wfv_pkg::ST_MUL_DC;
      wfv_pkg::ST_MUL_DC:   state_nxt = wfv_pkg::ST_DC_OUT;
      wfv_pkg::ST_DC_OUT:   state_nxt = wfv_pkg::ST_EMIT;
      wfv_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = wfv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wfv_pkg::ST_IDLE;
    endcase
  end

  // Control state: sequencer, clear sweep, pointers, filter memory, divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= wfv_pkg::ST_CLEAR;
      clr_r      <= '0;
      bw_r       <= '0;
      br_r       <= BP_W'(1);
      jw_r       <= '0;
      jr_r       <= JP_W'(1);
      div_cnt_r  <= '0;
      bore_out_r <= '0;
      lp_prev_r  <= '0;
      dc_in_r    <= '0;
      dc_out_r   <= '0;
      held_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_r <= clr_r + CLR_W'(1);
      end
      if (in_acc) begin
        if (in_tuser[0]) begin
          // note restart: rewind both rings
          jw_r <= jlen;
          jr_r <= '0;
          bw_r <= blen;
          br_r <= '0;
        end else begin
          div_cnt_r <= cnt_step;
        end
      end
      if (state_r == wfv_pkg::ST_JET_WR) begin
        jw_r <= jw_adv;
        jr_r <= jr_adv;
      end
      if (state_r == wfv_pkg::ST_LP_WR) begin
        lp_prev_r <= lp_new;
        bw_r      <= bw_adv;
        br_r      <= br_adv;
      end
      if (state_r == wfv_pkg::ST_DC_OUT) begin
        dc_in_r    <= lp_prev_r;
        dc_out_r   <= y_new;
        held_r     <= y_new;
        bore_out_r <= bore_rd_r;
      end
    end
  end

  // Datapath scratch registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_r     <= signed'(in_tdata[SB-1:0]);
      fresh_r <= (div_cnt_r == '0);
    end
    unique case (state_r)
      wfv_pkg::ST_SQ:    tmp_r <= sat_f(SW'(r13));
      wfv_pkg::ST_SHAPE: tmp_r <= sat_f(SW'(jet_rd_r) - SW'(r13));
      wfv_pkg::ST_REFL:  tmp_r <= sat_f(SW'(tmp_r) + SW'(r15));
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == wfv_pkg::ST_EMIT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == wfv_pkg::ST_EMIT && out_free) begin
      out_audio_r <= unsigned'(held_r);
      out_fresh_r <= fresh_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = TD_W'(out_audio_r);
  assign out_tuser[0] = out_fresh_r;

`ifndef SYNTHESIS
  a_fresh_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tuser[0] && div_cnt_r == '0) |=> state_r == wfv_pkg::ST_MUL_JET)
    else $error("computed sample did not enter the multiply sequence");

  a_held_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tuser[0] && div_cnt_r != '0) |=> state_r == wfv_pkg::ST_EMIT)
    else $error("held sample did not go straight to output");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wfv_pkg::ST_EMIT && out_free) |=> out_tvalid_r)
    else $error("output register not loaded on emit");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == wfv_pkg::ST_EMIT))
    else $error("output valid raised outside emit");

  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (clearing && clr_r != CLR_LAST) |=> (clearing && !in_tready))
    else $error("ring clear sweep ended early");
`endif

endmodule

`default_nettype wire

// ===== test/waveguide_flute_voice_tb.sv =====
`timescale 1ns / 1ps

module waveguide_flute_voice_tb;

  localparam int BORE_SLOTS  = 1024;
  localparam int JET_SLOTS   = 512;
  localparam longint SMP_MAX = 32767;
  localparam longint SMP_MIN = -32768;
  localparam longint DC_POLE = 32440;   // 0.99 in Q1.15
  // Longest quiet stretch: ring clear after reset, an input gap, an output
  // stall and the work on one computed sample, with a wide margin.
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 24;    // covers a computed sample still busy in the block

  // One output transaction: audio sample and fresh flag.
  typedef struct packed {
    logic [15:0] audio;
    logic        fresh;
  } tone_t;

  // One row of the directed table. 'typed' rows carry their own expectation.
  typedef struct {
    bit          restart;
    logic [15:0] pressure;
    bit          typed;
    logic [15:0] audio;
    bit          fresh;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [15:0] in_tdata = '0;     // [15:0] pressure
  logic [0:0]  in_tuser = '0;     // [0] mode (1 = restart)

  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [15:0] out_tdata;         // [15:0] audio
  wire  [0:0]  out_tuser;         // [0] fresh

  logic                           cfg_psel = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite = 1'b0;
  logic [wfv_pkg::APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [wfv_pkg::APB_DATA_W-1:0] cfg_pwdata = '0;
  wire  [wfv_pkg::APB_DATA_W-1:0] cfg_prdata;
  wire                            cfg_pready;

  waveguide_flute_voice u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Flute voice predictor: own copy of registers and waveguide state.
  // --------------------------------------------------------------------------
  int unsigned v_bore_len, v_jet_len, v_jet_gain, v_reed_gain, v_lp_coef, v_rate_div;
  longint      bore_ring [BORE_SLOTS];
  longint      jet_ring [JET_SLOTS];
  int unsigned bore_wp, bore_rp, jet_wp, jet_rp;
  longint      bore_tap, lp_last, dc_last_in, dc_last_out, last_audio;
  int unsigned div_phase;

  tone_t tone_q[$];     // expected output transactions, oldest first
  int    fail_count = 0;

  // Idling knobs, changed per phase; calm turns all idling off.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic longint clip16(longint v);
    if (v > SMP_MAX) return SMP_MAX;
    if (v < SMP_MIN) return SMP_MIN;
    return v;
  endfunction

  // Round half up then floor; >>> on a signed longint is a floor.
  function automatic longint round_down(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic int unsigned ring_next(int unsigned p, int unsigned len);
    return (p + 1 > len) ? 0 : p + 1;
  endfunction

  function automatic void voice_reset();
    v_bore_len  = wfv_pkg::BORE_LEN_RST;
    v_jet_len   = wfv_pkg::JET_LEN_RST;
    v_jet_gain  = wfv_pkg::JET_GAIN_RST;
    v_reed_gain = wfv_pkg::REED_GAIN_RST;
    v_lp_coef   = wfv_pkg::LP_COEF_RST;
    v_rate_div  = wfv_pkg::RATE_DIV_RST;
    foreach (bore_ring[i]) bore_ring[i] = 0;
    foreach (jet_ring[i]) jet_ring[i] = 0;
    bore_wp = 0; bore_rp = 1; jet_wp = 0; jet_rp = 1;
    bore_tap = 0; lp_last = 0; dc_last_in = 0; dc_last_out = 0;
    last_audio = 0; div_phase = 0;
  endfunction

  // Advances the voice by one input transaction; returns 1 with the expected
  // output when the transaction produces one (pressure), 0 for a restart.
  function automatic bit voice_step(input bit restart, input logic [15:0] praw,
                                    output tone_t res);
    int unsigned blen, jlen, div;
    longint p, x, x2, r, lp, y, g;
    blen = (v_bore_len > BORE_SLOTS - 1) ? BORE_SLOTS - 1 : v_bore_len;
    jlen = (v_jet_len > JET_SLOTS - 1) ? JET_SLOTS - 1 : v_jet_len;
    div  = (v_rate_div == 0) ? 1 : ((v_rate_div > 16) ? 16 : v_rate_div);
    res = '0;
    if (restart) begin
      jet_wp = jlen; jet_rp = 0;
      bore_wp = blen; bore_rp = 0;
      return 1'b0;
    end
    if (div_phase == 0) begin
      p = $signed(praw);
      g = v_jet_gain;
      jet_ring[jet_wp] = clip16(p + round_down(bore_tap * g, 15));
      jet_wp = ring_next(jet_wp, jlen);
      jet_rp = ring_next(jet_rp, jlen);
      x  = jet_ring[jet_rp];
      // cubic jet shaper x - x^3, then the reed reflection
      x2 = clip16(round_down(x * x, 13));
      r  = clip16(x - round_down(x2 * x, 13));
      g  = v_reed_gain;
      r  = clip16(r + round_down(bore_tap * g, 15));
      g  = v_lp_coef;
      lp = clip16(lp_last + round_down((r - lp_last) * g, 15));
      lp_last = lp;
      bore_ring[bore_wp] = lp;
      bore_wp = ring_next(bore_wp, blen);
      bore_rp = ring_next(bore_rp, blen);
      bore_tap = bore_ring[bore_rp];
      y = clip16(lp - dc_last_in + round_down(dc_last_out * DC_POLE, 15));
      dc_last_in  = lp;
      dc_last_out = y;
      last_audio  = y;
      res.fresh = 1'b1;
    end
    res.audio = last_audio[15:0];
    div_phase = div_phase + 1;
    if (div_phase >= div) div_phase = 0;
    return 1'b1;
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count = fail_count + 1;
  endtask

  // --------------------------------------------------------------------------
  // Output side: random backpressure bursts and the checker.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0 && !calm) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tone_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tone_q.size() == 0) begin
        flag_error($sformatf("output transaction with nothing expected, audio %h fresh %b",
                             out_tdata, out_tuser[0]));
      end else begin
        want = tone_q.pop_front();
        if (out_tdata !== want.audio)
          flag_error($sformatf("audio got %h want %h", out_tdata, want.audio));
        if (out_tuser[0] !== want.fresh)
          flag_error($sformatf("fresh got %b want %b", out_tuser[0], want.fresh));
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no transaction at all.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic cfg_write(input wfv_pkg::reg_idx_t idx, input int unsigned val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      wfv_pkg::REG_BORE_LEN:  v_bore_len  = val & 32'h3FF;
      wfv_pkg::REG_JET_LEN:   v_jet_len   = val & 32'h1FF;
      wfv_pkg::REG_JET_GAIN:  v_jet_gain  = val & 32'h7FFF;
      wfv_pkg::REG_REED_GAIN: v_reed_gain = val & 32'h7FFF;
      wfv_pkg::REG_LP_COEF:   v_lp_coef   = val & 32'h7FFF;
      wfv_pkg::REG_RATE_DIV:  v_rate_div  = val & 32'h1F;
      default: ;
    endcase
  endtask

  task automatic program_voice(input int unsigned bl, jl, jg, rg, lc, dv);
    cfg_write(wfv_pkg::REG_BORE_LEN, bl);
    cfg_write(wfv_pkg::REG_JET_LEN, jl);
    cfg_write(wfv_pkg::REG_JET_GAIN, jg);
    cfg_write(wfv_pkg::REG_REED_GAIN, rg);
    cfg_write(wfv_pkg::REG_LP_COEF, lc);
    cfg_write(wfv_pkg::REG_RATE_DIV, dv);
  endtask

  // One input transaction, with an optional idle burst in front of it.
  // The prediction is made at the accepting edge.
  task automatic send_sample(input bit restart, input logic [15:0] pres,
                             input bit typed, input tone_t fixed);
    tone_t pred;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pres;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
    if (voice_step(restart, pres, pred))
      tone_q.push_back(typed ? fixed : pred);
  endtask

  // Stop sending, wait for every expected output, then let a restart or a
  // held sample still in flight finish before registers change.
  task automatic drain_voice();
    in_tvalid <= 1'b0;
    while (tone_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic: mostly breath samples of varied shape, a few restarts.
  task automatic play_random(input int n);
    int unsigned pick;
    logic [15:0] pres;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      pres = $urandom_range(0, 65535);
      else if (pick < 80) pres = 16'($signed($urandom_range(0, 4095)) - 2048);
      else if (pick < 88) pres = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
      else                pres = 16'($signed($urandom_range(0, 2047)) +
                                 (($urandom_range(0, 1) != 0) ? 7168 : -9216));
      send_sample($urandom_range(0, 99) < 3, pres, 1'b0, '0);
    end
  endtask

  function automatic int unsigned pick_pct();
    int unsigned k;
    k = $urandom_range(0, 2);
    return (k == 0) ? 0 : ((k == 1) ? 10 : 35);
  endfunction

  stim_row_t dir_rows [16];

  initial begin
    // Just after reset both rings are zero, so the first five samples
    // read an empty jet line and must come out as fresh zeros.
    dir_rows = '{
      '{1'b0, 16'h7FFF, 1'b1, 16'h0000, 1'b1},
      '{1'b0, 16'h8000, 1'b1, 16'h0000, 1'b1},
      '{1'b0, 16'h0000, 1'b1, 16'h0000, 1'b1},
      '{1'b0, 16'h0001, 1'b1, 16'h0000, 1'b1},
      '{1'b0, 16'hFFFF, 1'b1, 16'h0000, 1'b1},
      '{1'b1, 16'h1234, 1'b0, 16'h0000, 1'b0},   // restart, pressure ignored
      '{1'b0, 16'h2000, 1'b0, 16'h0000, 1'b0},   // now reads back the -full-scale entry
      '{1'b0, 16'hE000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 16'h8000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 16'h4000, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 16'hC000, 1'b0, 16'h0000, 1'b0},
      '{1'b1, 16'h8000, 1'b0, 16'h0000, 1'b0},   // second restart mid-note
      '{1'b0, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 16'h0100, 1'b0, 16'h0000, 1'b0},
      '{1'b0, 16'hFF00, 1'b0, 16'h0000, 1'b0}
    };

    voice_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings; the ring clear stalls the first one.
    gap_pct = 10;
    stall_pct = 10;
    foreach (dir_rows[i])
      send_sample(dir_rows[i].restart, dir_rows[i].pressure, dir_rows[i].typed,
                  '{audio: dir_rows[i].audio, fresh: dir_rows[i].fresh});

    // Two-entry rings, full gains, divider of zero (acts as one).
    drain_voice();
    program_voice(1, 1, 32767, 32767, 32767, 0);
    play_random(200);

    // One-entry rings, all gains zero, slowest divider.
    drain_voice();
    program_voice(0, 0, 0, 0, 0, 16);
    play_random(150);

    // Longest rings, divider above the maximum (acts as sixteen).
    drain_voice();
    program_voice(1023, 511, $urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(0, 32767), 17);
    play_random(200);

    // Zero-length bore, divider field at its top code.
    drain_voice();
    program_voice(0, 5, 32767, 0, 16384, 31);
    play_random(150);

    // Short random voices that ring and build up; idling varies per phase.
    for (int ph = 0; ph < 5; ph++) begin
      drain_voice();
      gap_pct = pick_pct();
      stall_pct = pick_pct();
      program_voice($urandom_range(1, 80), $urandom_range(1, 40),
                    $urandom_range(8000, 32767), $urandom_range(8000, 32767),
                    $urandom_range(4000, 32767), $urandom_range(1, 4));
      play_random(200);
    end

    // Last part: no idling on either side.
    drain_voice();
    calm = 1'b1;
    program_voice($urandom_range(1, 200), $urandom_range(1, 60),
                  $urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(0, 32767), $urandom_range(1, 3));
    play_random(200);

    drain_voice();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
